// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/imupt_pkg.sv =====
// ----------------------------------------------------------------------------
// imupt_pkg
// Types, register codes, reset values and the arctangent table of the
// IMU prefilter and tilt-angle block.
// ----------------------------------------------------------------------------
package imupt_pkg;

	localparam int ANGLE_LIMIT = 25736;
	localparam int ATAN_IDX_W  = 5;
	localparam int ATAN_LEN    = 24;
	localparam int CORDIC_W    = 28;
	localparam int CORDIC_XY_W = 27;

	localparam logic signed [CORDIC_W-1:0] PI_Q24 = 28'sd52707179;

	localparam logic [15:0]        KEEP_RST  = 16'd32768;
	localparam logic [23:0]        SCALE_RST = 24'd17853;
	localparam logic signed [31:0] FB1_RST   = 32'sd2071735493;
	localparam logic signed [31:0] FB2_RST   = -32'sd1000494913;
	localparam logic signed [31:0] GAIN_RST  = 32'sd2501237;

	typedef enum logic [2:0] {
		REG_LPF_KEEP   = 3'd0,
		REG_GYRO_SCALE = 3'd1,
		REG_IIR_FB1    = 3'd2,
		REG_IIR_FB2    = 3'd3,
		REG_IIR_GAIN   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        keep_weight;
		logic [23:0]        rad_scale;
		logic signed [31:0] fb_one;
		logic signed [31:0] fb_two;
		logic signed [31:0] gain;
	} cfg_t;

	// first field in the highest bits
	typedef struct packed {
		logic signed [15:0] gyro_z_raw;
		logic signed [15:0] gyro_y_raw;
		logic signed [15:0] gyro_x_raw;
		logic signed [15:0] accel_z_raw;
		logic signed [15:0] accel_y_raw;
		logic signed [15:0] accel_x_raw;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] rate_z_passed;
		logic signed [15:0] rate_y_rad;
		logic signed [15:0] rate_x_rad;
		logic signed [23:0] accel_z_filtered;
		logic signed [23:0] accel_y_filtered;
		logic signed [23:0] accel_x_filtered;
	} result_t;

	// atan(2^-i), 24 fraction bits
	function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
		logic signed [CORDIC_W-1:0] v;
		case (i)
			5'd0:    v = 28'sd13176795;
			5'd1:    v = 28'sd7778716;
			5'd2:    v = 28'sd4110060;
			5'd3:    v = 28'sd2086331;
			5'd4:    v = 28'sd1047214;
			5'd5:    v = 28'sd524117;
			5'd6:    v = 28'sd262123;
			5'd7:    v = 28'sd131069;
			5'd8:    v = 28'sd65536;
			5'd9:    v = 28'sd32768;
			5'd10:   v = 28'sd16384;
			5'd11:   v = 28'sd8192;
			5'd12:   v = 28'sd4096;
			5'd13:   v = 28'sd2048;
			5'd14:   v = 28'sd1024;
			5'd15:   v = 28'sd512;
			5'd16:   v = 28'sd256;
			5'd17:   v = 28'sd128;
			5'd18:   v = 28'sd64;
			5'd19:   v = 28'sd32;
			5'd20:   v = 28'sd16;
			5'd21:   v = 28'sd8;
			5'd22:   v = 28'sd4;
			5'd23:   v = 28'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/imupt_queue.sv =====
// ----------------------------------------------------------------------------
// imupt_queue
// Front end: takes raw samples from the input stream into a two-entry queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imupt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  imupt_pkg::sample_t in_item,
	output logic              out_valid,
	input  logic              out_pop,
	output imupt_pkg::sample_t out_item
);

	imupt_pkg::sample_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q == 2'd3, "queue count out of range")
	`ASSERT_PROP(a_count_up, clk, arst_n, push && !pop |=> count_q == $past(count_q) + 2'd1, "queue count did not advance")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, out_pop && count_q == 2'd0, "pop from empty queue")

endmodule

// ===== src/imupt_cordic.sv =====
// ----------------------------------------------------------------------------
// imupt_cordic
// Iterative vectoring CORDIC: atan2(num, den) rounded to Q3.13 radians.
// ----------------------------------------------------------------------------
module imupt_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [23:0] num,
	input  logic signed [23:0] den,
	output logic               done,
	output logic signed [15:0] angle
);

	localparam int STEPS = (CORDIC_STEPS > imupt_pkg::ATAN_LEN) ?
		imupt_pkg::ATAN_LEN : CORDIC_STEPS;
	localparam logic [imupt_pkg::ATAN_IDX_W-1:0] LAST = imupt_pkg::ATAN_IDX_W'(STEPS - 1);
	localparam int XW = imupt_pkg::CORDIC_XY_W;
	localparam int ZW = imupt_pkg::CORDIC_W;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_ROUND} state_t;

	state_t                             state_q;
	logic signed [XW-1:0]               x_q;
	logic signed [XW-1:0]               y_q;
	logic signed [ZW-1:0]               z_q;
	logic [imupt_pkg::ATAN_IDX_W-1:0]   i_q;
	logic signed [XW-1:0]               sx;
	logic signed [XW-1:0]               sy;
	logic signed [ZW-1:0]               zr;
	logic signed [16:0]                 zq;

	assign sx = x_q >>> i_q;
	assign sy = y_q >>> i_q;
	assign zr = z_q + ZW'(1024);
	assign zq = 17'(zr >>> 11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			angle   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			i_q     <= '0;
		end else begin
			done <= (state_q == S_ROUND);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q <= '0;
						if (num == 24'sd0 && den == 24'sd0) begin
							x_q     <= '0;
							y_q     <= '0;
							z_q     <= '0;
							state_q <= S_ROUND;
						end else if (den < 0) begin
							// rotate into the right half-plane
							x_q     <= -XW'(den);
							y_q     <= -XW'(num);
							z_q     <= (num >= 0) ? imupt_pkg::PI_Q24 : -imupt_pkg::PI_Q24;
							state_q <= S_RUN;
						end else begin
							x_q     <= XW'(den);
							y_q     <= XW'(num);
							z_q     <= '0;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (y_q >= 0) begin
						x_q <= x_q + sy;
						y_q <= y_q - sx;
						z_q <= z_q + imupt_pkg::atan_lut(i_q);
					end else begin
						x_q <= x_q - sy;
						y_q <= y_q + sx;
						z_q <= z_q - imupt_pkg::atan_lut(i_q);
					end
					if (i_q == LAST) begin
						state_q <= S_ROUND;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_ROUND: begin
					if (zq > 17'sd25736) begin
						angle <= 16'sd25736;
					end else if (zq < -17'sd25736) begin
						angle <= -16'sd25736;
					end else begin
						angle <= 16'(zq);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/imupt_back.sv =====
// ----------------------------------------------------------------------------
// imupt_back
// Back end: filters, moving average, rate scaling and tilt angles of one
// sample on a shared multiplier and a shared CORDIC unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imupt_back #(
	parameter int WINDOW_LEN   = 5,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imupt_pkg::cfg_t    cfg,
	input  logic               in_valid,
	output logic               in_pop,
	input  imupt_pkg::sample_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output imupt_pkg::result_t out_item
);

	localparam int HIST    = WINDOW_LEN - 1;
	localparam int SUM_W   = 24 + $clog2(WINDOW_LEN);
	localparam int N_W     = SUM_W + 1;
	localparam int DIVISOR = 2 * WINDOW_LEN;
	localparam int D_W     = $clog2(DIVISOR + 1);
	localparam logic [63:0] RECIP = 64'h1_0000_0000 / 64'(DIVISOR);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_WAIT1, S_SUM, S_MUL2, S_WAIT2, S_FIX, S_PITCH, S_ROLL, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_IIR0, OP_IIR1, OP_IIR2, OP_AX0, OP_AX1, OP_AY0, OP_AY1, OP_GX0,
		OP_GX1, OP_GY0, OP_GY1, OP_DX, OP_DY, OP_DZ, OP_RX, OP_RY
	} op_t;

	state_t                    state_q;
	op_t                       op_q;
	op_t                       tag_s1;
	logic                      pv_s1;
	logic signed [65:0]        p_s1;
	logic signed [65:0]        acc_q;
	imupt_pkg::sample_t        item_q;

	logic signed [23:0]        prev_acc_q [2];
	logic signed [31:0]        hist_q [2];
	logic signed [23:0]        prev_rate_q [2];
	logic signed [23:0]        win_q [3][HIST];

	logic [N_W-1:0]            n_q [3];
	logic                      neg_q [3];
	logic [N_W-1:0]            q0_q [3];
	logic signed [23:0]        avg_q [3];
	logic signed [15:0]        rate_q [2];
	logic signed [15:0]        pitch_q;
	logic signed [15:0]        roll_q;
	logic                      cor_start_q;
	logic                      cor_sel_q;
	imupt_pkg::result_t        out_q;
	logic                      out_valid_q;

	logic signed [32:0]        ma;
	logic signed [32:0]        mb;
	logic signed [65:0]        sum_full;
	logic signed [65:0]        iir_val;
	logic signed [65:0]        lp_val;
	logic signed [65:0]        rt_val;
	logic signed [23:0]        cur [3];
	logic signed [SUM_W-1:0]   sum_c [3];
	logic [N_W-1:0]            n_c [3];
	logic signed [23:0]        avg_c [3];
	logic                      cor_done;
	logic signed [15:0]        cor_angle;
	logic signed [17:0]        wc;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return 32'(v);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
		if (v > 66'sd8388607) return 24'sh7fffff;
		if (v < -66'sd8388608) return 24'sh800000;
		return 24'(v);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
		if (v > 66'sd32767) return 16'sh7fff;
		if (v < -66'sd32768) return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic logic signed [32:0] raw8(input logic signed [15:0] s);
		return 33'($signed({s, 8'b0}));
	endfunction

	// weight of the new sample, 1 to 65536
	assign wc       = $signed(18'h10000 - {2'b0, cfg.keep_weight});
	assign in_pop   = (state_q == S_IDLE) && in_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// operand select of the shared multiplier
	always_comb begin
		unique case (op_q)
			OP_IIR0: begin ma = 33'(cfg.fb_one); mb = 33'(hist_q[0]); end
			OP_IIR1: begin ma = 33'(cfg.fb_two); mb = 33'(hist_q[1]); end
			OP_IIR2: begin ma = 33'(cfg.gain);   mb = raw8(item_q.accel_z_raw); end
			OP_AX0:  begin ma = raw8(item_q.accel_x_raw); mb = 33'(wc); end
			OP_AX1:  begin ma = 33'(prev_acc_q[0]); mb = $signed({17'b0, cfg.keep_weight}); end
			OP_AY0:  begin ma = raw8(item_q.accel_y_raw); mb = 33'(wc); end
			OP_AY1:  begin ma = 33'(prev_acc_q[1]); mb = $signed({17'b0, cfg.keep_weight}); end
			OP_GX0:  begin ma = raw8(item_q.gyro_x_raw); mb = 33'(wc); end
			OP_GX1:  begin ma = 33'(prev_rate_q[0]); mb = $signed({17'b0, cfg.keep_weight}); end
			OP_GY0:  begin ma = raw8(item_q.gyro_y_raw); mb = 33'(wc); end
			OP_GY1:  begin ma = 33'(prev_rate_q[1]); mb = $signed({17'b0, cfg.keep_weight}); end
			OP_DX:   begin ma = $signed(33'(n_q[0])); mb = $signed(RECIP[32:0]); end
			OP_DY:   begin ma = $signed(33'(n_q[1])); mb = $signed(RECIP[32:0]); end
			OP_DZ:   begin ma = $signed(33'(n_q[2])); mb = $signed(RECIP[32:0]); end
			OP_RX:   begin ma = 33'(prev_rate_q[0]); mb = $signed({9'b0, cfg.rad_scale}); end
			OP_RY:   begin ma = 33'(prev_rate_q[1]); mb = $signed({9'b0, cfg.rad_scale}); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign sum_full = acc_q + p_s1;
	assign iir_val  = (sum_full + 66'sd536870912) >>> 30;
	assign lp_val   = (sum_full + 66'sd32768) >>> 16;
	assign rt_val   = (p_s1 + 66'sd524288) >>> 20;

	assign cur[0] = prev_acc_q[0];
	assign cur[1] = prev_acc_q[1];
	assign cur[2] = sat24(66'(hist_q[0]));

	// window sums and round-half-away-from-zero divisor input
	always_comb begin
		logic [SUM_W-1:0] mag;
		for (int a = 0; a < 3; a++) begin
			sum_c[a] = SUM_W'(cur[a]);
			for (int k = 0; k < HIST; k++) begin
				sum_c[a] = sum_c[a] + SUM_W'(win_q[a][k]);
			end
			mag    = (sum_c[a] < 0) ? SUM_W'(-sum_c[a]) : SUM_W'(sum_c[a]);
			n_c[a] = {mag, 1'b0} + N_W'(WINDOW_LEN);
		end
	end

	// reciprocal quotient is exact or one short
	always_comb begin
		logic [N_W+D_W-1:0] rem;
		logic [N_W-1:0]     q;
		logic signed [N_W:0] sv;
		for (int a = 0; a < 3; a++) begin
			rem = (N_W+D_W)'(n_q[a]) - (N_W+D_W)'(q0_q[a]) * (N_W+D_W)'(DIVISOR);
			q   = (rem >= (N_W+D_W)'(DIVISOR)) ? q0_q[a] + 1'b1 : q0_q[a];
			sv  = neg_q[a] ? -$signed({1'b0, q}) : $signed({1'b0, q});
			avg_c[a] = sat24(66'(sv));
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= ma * mb;
		tag_s1 <= op_q;
	end

	// consume the registered products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			prev_acc_q[0]  <= '0;
			prev_acc_q[1]  <= '0;
			hist_q[0]      <= '0;
			hist_q[1]      <= '0;
			prev_rate_q[0] <= '0;
			prev_rate_q[1] <= '0;
			for (int a = 0; a < 3; a++) begin
				q0_q[a] <= '0;
			end
			rate_q[0] <= '0;
			rate_q[1] <= '0;
		end else if (pv_s1) begin
			unique case (tag_s1)
				OP_IIR0: acc_q <= p_s1;
				OP_IIR1: acc_q <= sum_full;
				OP_IIR2: begin
					hist_q[1] <= hist_q[0];
					hist_q[0] <= sat32(iir_val);
				end
				OP_AX0, OP_AY0, OP_GX0, OP_GY0: acc_q <= p_s1;
				OP_AX1: prev_acc_q[0]  <= sat24(lp_val);
				OP_AY1: prev_acc_q[1]  <= sat24(lp_val);
				OP_GX1: prev_rate_q[0] <= sat24(lp_val);
				OP_GY1: prev_rate_q[1] <= sat24(lp_val);
				OP_DX:  q0_q[0] <= p_s1[32 +: N_W];
				OP_DY:  q0_q[1] <= p_s1[32 +: N_W];
				OP_DZ:  q0_q[2] <= p_s1[32 +: N_W];
				OP_RX:  rate_q[0] <= sat16(rt_val);
				OP_RY:  rate_q[1] <= sat16(rt_val);
				default: acc_q <= acc_q;
			endcase
		end
	end

	// window history: shift in after the sums are taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < HIST; k++) begin
					win_q[a][k] <= '0;
				end
			end
		end else if (state_q == S_SUM) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = HIST - 1; k > 0; k--) begin
					win_q[a][k] <= win_q[a][k-1];
				end
				win_q[a][0] <= cur[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_IIR0;
			pv_s1       <= 1'b0;
			cor_start_q <= 1'b0;
			cor_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
			item_q      <= '0;
			out_q       <= '0;
			pitch_q     <= '0;
			roll_q      <= '0;
			for (int a = 0; a < 3; a++) begin
				n_q[a]   <= '0;
				neg_q[a] <= 1'b0;
				avg_q[a] <= '0;
			end
		end else begin
			pv_s1       <= (state_q == S_MUL1) || (state_q == S_MUL2);
			cor_start_q <= (state_q == S_FIX) || ((state_q == S_PITCH) && cor_done);
			// load on the output step, drop once the transfer is taken
			if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						op_q    <= OP_IIR0;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					op_q <= op_t'(op_q + 4'd1);
					if (op_q == OP_GY1) begin
						state_q <= S_WAIT1;
					end
				end
				S_WAIT1: state_q <= S_SUM;
				S_SUM: begin
					for (int a = 0; a < 3; a++) begin
						n_q[a]   <= n_c[a];
						neg_q[a] <= (sum_c[a] < 0);
					end
					op_q    <= OP_DX;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					op_q <= op_t'(op_q + 4'd1);
					if (op_q == OP_RY) begin
						state_q <= S_WAIT2;
					end
				end
				S_WAIT2: state_q <= S_FIX;
				S_FIX: begin
					for (int a = 0; a < 3; a++) begin
						avg_q[a] <= avg_c[a];
					end
					cor_sel_q <= 1'b0;
					state_q   <= S_PITCH;
				end
				S_PITCH: begin
					if (cor_done) begin
						pitch_q   <= -cor_angle;
						cor_sel_q <= 1'b1;
						state_q   <= S_ROLL;
					end
				end
				S_ROLL: begin
					if (cor_done) begin
						roll_q  <= cor_angle;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output slot is free
					if (!out_valid_q || out_ready) begin
						out_q.accel_x_filtered <= avg_q[0];
						out_q.accel_y_filtered <= avg_q[1];
						out_q.accel_z_filtered <= avg_q[2];
						out_q.rate_x_rad       <= rate_q[0];
						out_q.rate_y_rad       <= rate_q[1];
						out_q.rate_z_passed    <= item_q.gyro_z_raw;
						out_q.pitch_angle      <= pitch_q;
						out_q.roll_angle       <= roll_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	imupt_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cor_start_q),
		.num   (cor_sel_q ? avg_q[1] : avg_q[0]),
		.den   (avg_q[2]),
		.done  (cor_done),
		.angle (cor_angle)
	);

	`ASSERT_PROP(a_prod_in_seq, clk, arst_n, pv_s1 |-> (state_q == S_MUL1 || state_q == S_WAIT1 || state_q == S_MUL2 || state_q == S_WAIT2), "product consumed outside a multiply phase")
	`ASSERT_PROP(a_out_from_seq, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_OUT), "result raised outside output step")
	`ASSERT_PROP(a_cordic_done, clk, arst_n, cor_done |-> (state_q == S_PITCH || state_q == S_ROLL), "angle done while not waiting")

endmodule

// ===== src/imu_prefilter_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// imu_prefilter_tilt_angles
// IMU prefilter: low-pass and IIR accel filters, moving average, gyro rate
// scaling and pitch/roll by CORDIC atan2.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    six raw samples, 96 bits
//  m_axis    out        m_axis_tvalid/tready    filtered values and angles, 152 bits
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  Each sample is worked on the shared multiplier (16 products) and on the
//  shared CORDIC unit, which is run once per angle.
//  A two-entry input queue keeps accepting while a sample is being worked.
//  The output register holds a result until taken; the next result waits.
//  Reset clears filter history and loads the register defaults.
// ----------------------------------------------------------------------------
module imu_prefilter_tilt_angles #(
	parameter int WINDOW_LEN   = 5,
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// accel_x_filtered, accel_y_filtered, accel_z_filtered, rate_x_rad,
	// rate_y_rad, rate_z_passed, pitch_angle, roll_angle
	output logic [151:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	imupt_pkg::cfg_t    cfg_q;
	imupt_pkg::sample_t q_item;
	imupt_pkg::result_t res;
	logic               q_valid;
	logic               q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_weight <= imupt_pkg::KEEP_RST;
			cfg_q.rad_scale   <= imupt_pkg::SCALE_RST;
			cfg_q.fb_one      <= imupt_pkg::FB1_RST;
			cfg_q.fb_two      <= imupt_pkg::FB2_RST;
			cfg_q.gain        <= imupt_pkg::GAIN_RST;
		end else if (cfg_valid) begin
			unique case (imupt_pkg::reg_idx_t'(cfg_index))
				imupt_pkg::REG_LPF_KEEP:   cfg_q.keep_weight <= cfg_data[15:0];
				imupt_pkg::REG_GYRO_SCALE: cfg_q.rad_scale   <= cfg_data[23:0];
				imupt_pkg::REG_IIR_FB1:    cfg_q.fb_one      <= $signed(cfg_data);
				imupt_pkg::REG_IIR_FB2:    cfg_q.fb_two      <= $signed(cfg_data);
				imupt_pkg::REG_IIR_GAIN:   cfg_q.gain        <= $signed(cfg_data);
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	imupt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (imupt_pkg::sample_t'(s_axis_tdata)),
		.out_valid(q_valid),
		.out_pop  (q_pop),
		.out_item (q_item)
	);

	imupt_back #(
		.WINDOW_LEN  (WINDOW_LEN),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (q_valid),
		.in_pop   (q_pop),
		.in_item  (q_item),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_item (res)
	);

	assign m_axis_tdata = res;

endmodule
